// ----- design/brsd_pkg.sv -----
// Package for the bright region swipe detector.
// Types, register codes, constants and helpers shared by the brsd modules.
// No dependencies.
package brsd_pkg;

  // Default run saturation depth
  localparam int unsigned HISTORY_DEPTH_DEF = 64;

  // Event queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // Frame geometry limits
  localparam logic [11:0] MAX_DIM = 12'd2048;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // Field widths
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned RUNF_W  = 7;
  localparam int unsigned TICK_W  = 32;

  // Input request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Register indexes (word address paddr[4:2])
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_PIXEL_THRESHOLD = 3'd2,
    REG_COUNT_THRESHOLD = 3'd3,
    REG_MIN_RUN         = 3'd4,
    REG_COOLDOWN_TICKS  = 3'd5
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [PIX_W-1:0]   pixel_threshold;
    logic [COUNT_W-1:0] count_threshold;
    logic [RUNF_W-1:0]  min_run;
    logic [TICK_W-1:0]  cooldown_ticks;
  } cfg_t;

  // Input transaction
  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [COUNT_W-1:0] bright_count;
    logic [RUNF_W-1:0]  run_length;
    logic               swipe;
  } out_item_t;

  // Queue entry: a tick or a finished frame with its count
  typedef struct packed {
    logic               is_tick;
    logic [COUNT_W-1:0] count;
  } evt_t;

  // Zero reads as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = {{(DIM_W-1){1'b0}}, 1'b1};
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end
    return r;
  endfunction

endpackage

// ----- design/brsd_stream_if.sv -----
// Valid/ready stream interface used by every brsd channel but the APB register port.
// Payload type is a parameter; no package dependency.
interface brsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/brsd_cfg_regs.sv -----
// APB-style register file for the bright region swipe detector.
// Depends on brsd_pkg.
module brsd_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output brsd_pkg::cfg_t                  cfg_o
);
  import brsd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  cfg_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cfg_reg_e'(paddr[4:2]);

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:     cfg_d.frame_width     = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:    cfg_d.frame_height    = pwdata[DIM_W-1:0];
        REG_PIXEL_THRESHOLD: cfg_d.pixel_threshold = pwdata[PIX_W-1:0];
        REG_COUNT_THRESHOLD: cfg_d.count_threshold = pwdata[COUNT_W-1:0];
        REG_MIN_RUN:         cfg_d.min_run         = pwdata[RUNF_W-1:0];
        REG_COOLDOWN_TICKS:  cfg_d.cooldown_ticks  = pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FRAME_WIDTH:     prdata = CFG_DATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:    prdata = CFG_DATA_W'(cfg_q.frame_height);
      REG_PIXEL_THRESHOLD: prdata = CFG_DATA_W'(cfg_q.pixel_threshold);
      REG_COUNT_THRESHOLD: prdata = CFG_DATA_W'(cfg_q.count_threshold);
      REG_MIN_RUN:         prdata = CFG_DATA_W'(cfg_q.min_run);
      REG_COOLDOWN_TICKS:  prdata = CFG_DATA_W'(cfg_q.cooldown_ticks);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= 12'd640;
      cfg_q.frame_height    <= 12'd240;
      cfg_q.pixel_threshold <= 8'd100;
      cfg_q.count_threshold <= 22'd30000;
      cfg_q.min_run         <= 7'd5;
      cfg_q.cooldown_ticks  <= 32'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/brsd_front.sv -----
// Front end: accepts pixels and ticks, tracks raster position and the
// bright count, and queues tick and frame-end events. Depends on brsd_pkg.
module brsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brsd_pkg::cfg_t cfg_i,
  brsd_stream_if.sink    in_i,
  brsd_stream_if.source  evt_o
);
  import brsd_pkg::*;

  logic [POS_W-1:0]   col_q, col_d;
  logic [POS_W-1:0]   row_q, row_d;
  logic [COUNT_W-1:0] frame_q, frame_d;

  logic [DIM_W-1:0]   w, h, half_h;
  logic               fire, is_tick, last_col, last_row, hit;
  logic [COUNT_W-1:0] count_next;

  // Accept whenever the queue has room
  assign in_i.ready = evt_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign is_tick    = (in_i.payload.req_type == REQ_TICK);

  // Geometry and pixel classification
  assign w        = clamp_dim(cfg_i.frame_width);
  assign h        = clamp_dim(cfg_i.frame_height);
  assign half_h   = h >> 1;
  assign last_col = ({1'b0, col_q} + 12'd1) >= w;
  assign last_row = ({1'b0, row_q} + 12'd1) >= h;
  assign hit      = ({1'b0, row_q} < half_h) &&
                    (in_i.payload.pixel_value >= cfg_i.pixel_threshold);
  assign count_next = frame_q + COUNT_W'(hit);

  // Raster walk
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    frame_d = frame_q;
    if (fire && !is_tick) begin
      if (!last_col) begin
        col_d   = col_q + 1'b1;
        frame_d = count_next;
      end else begin
        col_d = '0;
        if (!last_row) begin
          row_d   = row_q + 1'b1;
          frame_d = count_next;
        end else begin
          row_d   = '0;
          frame_d = '0;
        end
      end
    end
  end

  // Ticks and frame ends go to the back end in arrival order
  assign evt_o.valid         = fire && (is_tick || (last_col && last_row));
  assign evt_o.payload.is_tick = is_tick;
  assign evt_o.payload.count   = count_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      frame_q <= frame_d;
    end
  end

endmodule

// ----- design/brsd_queue.sv -----
// Small event queue decoupling the front end from the back end.
// Depends on brsd_pkg.
module brsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  brsd_stream_if.sink   push_i,
  brsd_stream_if.source pop_o
);
  import brsd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_i.ready  = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_o.valid   = (cnt_q != '0);
  assign pop_o.payload = mem_q[rd_q];
  assign push          = push_i.valid && push_i.ready;
  assign pop           = pop_o.valid && pop_o.ready;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue occupancy missed a push");

endmodule

// ----- design/brsd_back.sv -----
// Back end: run tracking, cooldown tick counter, swipe decision and
// the result register. Depends on brsd_pkg.
module brsd_back #(
  parameter int unsigned HISTORY_DEPTH = brsd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brsd_pkg::cfg_t cfg_i,
  brsd_stream_if.sink    evt_i,
  brsd_stream_if.source  out_o
);
  import brsd_pkg::*;

  localparam int unsigned RUN_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CMP_W = (RUN_W > RUNF_W) ? RUN_W : RUNF_W;
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(HISTORY_DEPTH);

  logic [RUN_W-1:0]   run_q, run_d;
  logic [COUNT_W-1:0] prev_q, prev_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               fire, frame_fire, swipe_now;
  logic [RUN_W-1:0]   run_next;
  logic [CMP_W-1:0]   run_ext;

  // Ticks never need the output slot
  assign evt_i.ready = evt_i.payload.is_tick || !out_valid_q || out_o.ready;
  assign fire        = evt_i.valid && evt_i.ready;
  assign frame_fire  = fire && !evt_i.payload.is_tick;

  // Rising run update
  always_comb begin
    if (evt_i.payload.count < cfg_i.count_threshold) begin
      run_next = '0;
    end else if ((run_q != '0) && (evt_i.payload.count > prev_q)) begin
      run_next = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
    end else begin
      run_next = {{(RUN_W-1){1'b0}}, 1'b1};
    end
  end

  assign run_ext   = CMP_W'(run_next);
  assign swipe_now = (run_ext >= CMP_W'(cfg_i.min_run)) &&
                     (ticks_q > cfg_i.cooldown_ticks);

  // State and result update
  always_comb begin
    run_d       = run_q;
    prev_d      = prev_q;
    ticks_d     = ticks_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fire && evt_i.payload.is_tick) begin
      if (ticks_q != '1) ticks_d = ticks_q + 1'b1;
    end
    if (frame_fire) begin
      run_d              = run_next;
      prev_d             = evt_i.payload.count;
      out_valid_d        = 1'b1;
      out_d.bright_count = evt_i.payload.count;
      out_d.run_length   = run_ext[RUNF_W-1:0];
      out_d.swipe        = swipe_now;
      if (swipe_now) ticks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      prev_q      <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      prev_q      <= prev_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Checks
  a_swipe_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_fire && swipe_now) |=> (ticks_q == '0))
    else $error("swipe did not restart the tick counter");

  a_run_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RUN_MAX)
    else $error("run length above history depth");

endmodule

// ----- design/bright_region_swipe_detector_unit.sv -----
// Top level of the bright region swipe detector.
// Depends on brsd_pkg, brsd_stream_if, brsd_cfg_regs, brsd_front,
// brsd_queue and brsd_back.
//
//   channel  dir  payload                               handshake
//   in_i     in   req_type, pixel_value                 valid/ready
//   out_o    out  bright_count, run_length, swipe       valid/ready
//   apb      in   6 registers at paddr 4*i, 32 bit      psel/penable, pready=1
//
// One input transaction per cycle sustained; the front end classifies and
// counts each pixel as it arrives. A frame result passes through the queue
// entry and then the result register in the back end.
// A 4-entry event queue lets ticks and frame ends ride through an output
// stall; input stalls only when that queue is full.
// Reset clears raster position, counts, run, tick counter and the queue,
// and loads the register defaults.
module bright_region_swipe_detector_unit #(
  parameter int unsigned HISTORY_DEPTH = brsd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  brsd_stream_if.sink                     in_i,
  brsd_stream_if.source                   out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import brsd_pkg::*;

  cfg_t cfg;

  brsd_stream_if #(.payload_t(evt_t)) push_if ();
  brsd_stream_if #(.payload_t(evt_t)) pop_if ();

  // Registers
  brsd_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pixel and tick intake
  brsd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .evt_o  (push_if)
  );

  // Event queue
  brsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_if),
    .pop_o  (pop_if)
  );

  // Run, cooldown and results
  brsd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .evt_i  (pop_if),
    .out_o  (out_o)
  );

endmodule
